// ===== rtl/gpioirq_pkg.sv =====
// Shared types, request and register codes for the GPIO port with interrupt detection.
`timescale 1ns / 1ps

package gpioirq_pkg;

	localparam int WORD_W        = 32;
	localparam int PIN_COUNT_DEF = 32;
	localparam int PINS_PER_ICR  = 16;
	localparam int MODE_W        = 2;

	// Request types
	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_DATA   = 3'd0;
	localparam logic [2:0] REG_DIR    = 3'd1;
	localparam logic [2:0] REG_ICR_LO = 3'd2;
	localparam logic [2:0] REG_ICR_HI = 3'd3;
	localparam logic [2:0] REG_MASK   = 3'd4;
	localparam logic [2:0] REG_STATUS = 3'd5;
	localparam logic [2:0] REG_BOTH   = 3'd6;

	// Per-pin detection modes
	localparam logic [1:0] MODE_LOW  = 2'd0;
	localparam logic [1:0] MODE_HIGH = 2'd1;
	localparam logic [1:0] MODE_RISE = 2'd2;
	localparam logic [1:0] MODE_FALL = 2'd3;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [2:0]        reg_index;
		logic [WORD_W-1:0] write_data;
		logic [WORD_W-1:0] pin_levels;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic [WORD_W-1:0] pad_out;
		logic [WORD_W-1:0] pad_drive_enable;
		logic              irq;
	} rsp_t;

endpackage

// ===== rtl/gpioirq_lane.sv =====
// Per-pin interrupt condition detector, one instance per implemented pin.
`timescale 1ns / 1ps

module gpioirq_lane (
	input  logic                            now,
	input  logic                            prev,
	input  logic [gpioirq_pkg::MODE_W-1:0]  mode,
	input  logic                            both,
	output logic                            hit
);

	logic rise;
	logic fall;

	assign rise = now & ~prev;
	assign fall = ~now & prev;

	always_comb begin
		if (both) begin
			hit = rise | fall;
		end else begin
			case (mode)
				gpioirq_pkg::MODE_LOW:  hit = ~now;
				gpioirq_pkg::MODE_HIGH: hit = now;
				gpioirq_pkg::MODE_RISE: hit = rise;
				gpioirq_pkg::MODE_FALL: hit = fall;
				default:                hit = 1'b0;
			endcase
		end
	end

endmodule

// ===== rtl/gpioirq_skid.sv =====
// Two-entry output stage: result register plus skid register.
`timescale 1ns / 1ps

module gpioirq_skid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gpioirq_pkg::rsp_t   push_data,
	output logic                full,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output gpioirq_pkg::rsp_t   rsp
);

	logic              main_valid_q;
	logic              skid_valid_q;
	gpioirq_pkg::rsp_t main_q;
	gpioirq_pkg::rsp_t skid_q;
	logic              pop;

	assign pop       = main_valid_q & ~rsp_stall;
	assign full      = skid_valid_q;
	assign rsp_valid = main_valid_q;
	assign rsp       = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

// ===== rtl/gpio_port_with_irq_detect.sv =====
// Top level of the GPIO port with per-pin edge and level interrupt detection.
`timescale 1ns / 1ps

// Usage:
//   One request channel (req_valid / req_stall / req) carries register reads,
//   register writes and pin sample ticks. One response channel
//   (rsp_valid / rsp_stall / rsp) returns exactly one response per request,
//   in order: read data (zero unless a read), pad drive values, pad drive
//   enables and the interrupt line, all taken after the request's update.
//   Throughput: one request per clock while req_stall is low. The response is
//   registered: register update, the per-pin lane detectors and the merge
//   are all combinational logic in front of the response register.
//   A stalled response waits in the output register; one more request is still
//   taken and parked in the skid register, after which req_stall rises until
//   the receiver drains a response. req_stall is driven from a flop.
//   Reset clears every architectural register: all pins inputs, all interrupts
//   masked, status clear, previous sample zero (so a pin high on the first
//   tick counts as a rising edge). The output stage comes out of reset empty.
//   Pins at or above PIN_COUNT never set status and are never driven; their
//   register bits still store and read back.

module gpio_port_with_irq_detect #(
	parameter int PIN_COUNT = gpioirq_pkg::PIN_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  gpioirq_pkg::req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output gpioirq_pkg::rsp_t rsp
);

	localparam int W = gpioirq_pkg::WORD_W;
	localparam logic [W-1:0] PIN_MASK =
		(PIN_COUNT >= W) ? {W{1'b1}} : ((W'(1) << PIN_COUNT) - W'(1));

	// Architectural registers
	logic [W-1:0] data_q, dir_q, icr_lo_q, icr_hi_q, mask_q, status_q, both_q, prev_q;
	logic [W-1:0] data_d, dir_d, icr_lo_d, icr_hi_d, mask_d, status_d, both_d, prev_d;

	logic              accept;
	logic [W-1:0]      hits;
	logic [W-1:0]      rdata;
	gpioirq_pkg::rsp_t result;

	assign accept = req_valid & ~req_stall;

	// One detection lane per implemented pin; higher pins never hit
	for (genvar i = 0; i < W; i++) begin : g_lane
		if (i < PIN_COUNT) begin : g_on
			localparam int MI = (i % gpioirq_pkg::PINS_PER_ICR) * gpioirq_pkg::MODE_W;
			logic [gpioirq_pkg::MODE_W-1:0] mode;

			if (i < gpioirq_pkg::PINS_PER_ICR) begin : g_lo
				assign mode = icr_lo_q[MI +: gpioirq_pkg::MODE_W];
			end else begin : g_hi
				assign mode = icr_hi_q[MI +: gpioirq_pkg::MODE_W];
			end

			gpioirq_lane u_lane (
				.now  (req.pin_levels[i]),
				.prev (prev_q[i]),
				.mode (mode),
				.both (both_q[i]),
				.hit  (hits[i])
			);
		end else begin : g_off
			assign hits[i] = 1'b0;
		end
	end

	// Register read mux; reads change nothing
	always_comb begin
		case (req.reg_index)
			gpioirq_pkg::REG_DATA:   rdata = data_q;
			gpioirq_pkg::REG_DIR:    rdata = dir_q;
			gpioirq_pkg::REG_ICR_LO: rdata = icr_lo_q;
			gpioirq_pkg::REG_ICR_HI: rdata = icr_hi_q;
			gpioirq_pkg::REG_MASK:   rdata = mask_q;
			gpioirq_pkg::REG_STATUS: rdata = status_q;
			gpioirq_pkg::REG_BOTH:   rdata = both_q;
			default:                 rdata = '0;
		endcase
	end

	// Next-state logic: hold unless an accepted request updates a register
	always_comb begin
		data_d   = data_q;
		dir_d    = dir_q;
		icr_lo_d = icr_lo_q;
		icr_hi_d = icr_hi_q;
		mask_d   = mask_q;
		status_d = status_q;
		both_d   = both_q;
		prev_d   = prev_q;
		if (accept) begin
			case (req.req_type)
				gpioirq_pkg::REQ_WRITE: begin
					case (req.reg_index)
						gpioirq_pkg::REG_DATA:   data_d   = req.write_data;
						gpioirq_pkg::REG_DIR:    dir_d    = req.write_data;
						gpioirq_pkg::REG_ICR_LO: icr_lo_d = req.write_data;
						gpioirq_pkg::REG_ICR_HI: icr_hi_d = req.write_data;
						gpioirq_pkg::REG_MASK:   mask_d   = req.write_data;
						// write one to clear
						gpioirq_pkg::REG_STATUS: status_d = status_q & ~req.write_data;
						gpioirq_pkg::REG_BOTH:   both_d   = req.write_data;
						default:                 ;
					endcase
				end
				gpioirq_pkg::REQ_TICK: begin
					// merge lane hits into status, regardless of mask
					status_d = status_q | hits;
					prev_d   = req.pin_levels;
				end
				default: ;
			endcase
		end
	end

	// Response is built from the post-update state
	always_comb begin
		result.read_data        = (req.req_type == gpioirq_pkg::REQ_READ) ? rdata : '0;
		result.pad_out          = data_d & dir_d & PIN_MASK;
		result.pad_drive_enable = dir_d & PIN_MASK;
		result.irq              = |(status_d & mask_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q   <= '0;
			dir_q    <= '0;
			icr_lo_q <= '0;
			icr_hi_q <= '0;
			mask_q   <= '0;
			status_q <= '0;
			both_q   <= '0;
			prev_q   <= '0;
		end else begin
			data_q   <= data_d;
			dir_q    <= dir_d;
			icr_lo_q <= icr_lo_d;
			icr_hi_q <= icr_hi_d;
			mask_q   <= mask_d;
			status_q <= status_d;
			both_q   <= both_d;
			prev_q   <= prev_d;
		end
	end

	gpioirq_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.full      (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== verif/gpio_port_with_irq_detect_tb.sv =====
// Self-checking testbench for the GPIO port with per-pin interrupt detection.
`timescale 1ns / 1ps

module gpio_port_with_irq_detect_tb;

	localparam int WORD_W       = gpioirq_pkg::WORD_W;
	localparam int MODE_W       = gpioirq_pkg::MODE_W;
	localparam int PINS_PER_ICR = gpioirq_pkg::PINS_PER_ICR;
	localparam int PIN_COUNT    = gpioirq_pkg::PIN_COUNT_DEF;
	localparam logic [WORD_W-1:0] PIN_MASK =
		(PIN_COUNT >= WORD_W) ? 32'hFFFF_FFFF : ((32'd1 << PIN_COUNT) - 32'd1);

	// Codes the package leaves unnamed: the spare request type and register slot
	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam logic [2:0] REG_SPARE = 3'd7;

	localparam int RANDOM_REQUESTS = 1400;

	// Predicts the port's registers and checks every response against them.
	class gpio_irq_scoreboard;
		logic [WORD_W-1:0] data_word;
		logic [WORD_W-1:0] dir_word;
		logic [WORD_W-1:0] mode_lo_word;
		logic [WORD_W-1:0] mode_hi_word;
		logic [WORD_W-1:0] mask_word;
		logic [WORD_W-1:0] status_word;
		logic [WORD_W-1:0] both_word;
		logic [WORD_W-1:0] last_sample;
		gpioirq_pkg::rsp_t pending_rsp[$];
		int                errors;

		function new();
			data_word    = '0;
			dir_word     = '0;
			mode_lo_word = '0;
			mode_hi_word = '0;
			mask_word    = '0;
			status_word  = '0;
			both_word    = '0;
			last_sample  = '0;
			errors       = 0;
		endfunction

		// Work out which pins meet their detection condition on this sample
		function logic [WORD_W-1:0] pin_hits(logic [WORD_W-1:0] now);
			logic [WORD_W-1:0] rise;
			logic [WORD_W-1:0] fall;
			logic [WORD_W-1:0] hits;
			logic [1:0]        mode;
			rise = now & ~last_sample;
			fall = ~now & last_sample;
			hits = '0;
			for (int i = 0; i < WORD_W; i++) begin
				mode = (i < PINS_PER_ICR) ? mode_lo_word[MODE_W*i +: MODE_W]
					: mode_hi_word[MODE_W*(i-PINS_PER_ICR) +: MODE_W];
				if (both_word[i]) begin
					hits[i] = rise[i] | fall[i];
				end else begin
					case (mode)
						gpioirq_pkg::MODE_LOW:  hits[i] = ~now[i];
						gpioirq_pkg::MODE_HIGH: hits[i] = now[i];
						gpioirq_pkg::MODE_RISE: hits[i] = rise[i];
						default:                hits[i] = fall[i];
					endcase
				end
			end
			return hits & PIN_MASK;
		endfunction

		// Apply one accepted request and queue the response it must produce
		function void apply_request(gpioirq_pkg::req_t r);
			gpioirq_pkg::rsp_t exp_rsp;
			exp_rsp.read_data = '0;
			case (r.req_type)
				gpioirq_pkg::REQ_READ: begin
					case (r.reg_index)
						gpioirq_pkg::REG_DATA:   exp_rsp.read_data = data_word;
						gpioirq_pkg::REG_DIR:    exp_rsp.read_data = dir_word;
						gpioirq_pkg::REG_ICR_LO: exp_rsp.read_data = mode_lo_word;
						gpioirq_pkg::REG_ICR_HI: exp_rsp.read_data = mode_hi_word;
						gpioirq_pkg::REG_MASK:   exp_rsp.read_data = mask_word;
						gpioirq_pkg::REG_STATUS: exp_rsp.read_data = status_word;
						gpioirq_pkg::REG_BOTH:   exp_rsp.read_data = both_word;
						default:                 exp_rsp.read_data = '0;
					endcase
				end
				gpioirq_pkg::REQ_WRITE: begin
					case (r.reg_index)
						gpioirq_pkg::REG_DATA:   data_word    = r.write_data;
						gpioirq_pkg::REG_DIR:    dir_word     = r.write_data;
						gpioirq_pkg::REG_ICR_LO: mode_lo_word = r.write_data;
						gpioirq_pkg::REG_ICR_HI: mode_hi_word = r.write_data;
						gpioirq_pkg::REG_MASK:   mask_word    = r.write_data;
						gpioirq_pkg::REG_STATUS: status_word  = status_word & ~r.write_data;
						gpioirq_pkg::REG_BOTH:   both_word    = r.write_data;
						default:                 ;
					endcase
				end
				gpioirq_pkg::REQ_TICK: begin
					status_word = status_word | pin_hits(r.pin_levels);
					last_sample = r.pin_levels;
				end
				default: ;
			endcase
			exp_rsp.pad_out          = data_word & dir_word & PIN_MASK;
			exp_rsp.pad_drive_enable = dir_word & PIN_MASK;
			exp_rsp.irq              = |(status_word & mask_word);
			pending_rsp.push_back(exp_rsp);
		endfunction

		function void check_field(string label, logic [WORD_W-1:0] exp_val,
			logic [WORD_W-1:0] got_val);
			if (got_val !== exp_val) begin
				errors++;
				$display("%0t ns: %s mismatch, expected %h, actual %h",
					$time, label, exp_val, got_val);
			end
		endfunction

		// Compare one accepted response with the oldest prediction
		function void compare_response(gpioirq_pkg::rsp_t got);
			gpioirq_pkg::rsp_t exp_rsp;
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("%0t ns: response with none expected, actual %h", $time, got);
				return;
			end
			exp_rsp = pending_rsp.pop_front();
			check_field("read_data", exp_rsp.read_data, got.read_data);
			check_field("pad_out", exp_rsp.pad_out, got.pad_out);
			check_field("pad_drive_enable", exp_rsp.pad_drive_enable, got.pad_drive_enable);
			check_field("irq", {31'd0, exp_rsp.irq}, {31'd0, got.irq});
		endfunction

		function int outstanding();
			return pending_rsp.size();
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	gpioirq_pkg::req_t req       = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	gpioirq_pkg::rsp_t rsp;

	gpio_irq_scoreboard port_model;
	logic [WORD_W-1:0]  sent_levels = '0;
	bit                 burst_mode  = 1'b0;

	gpio_port_with_irq_detect #(
		.PIN_COUNT(PIN_COUNT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Idle gap before the next request: mostly back to back, a few long pauses
	function automatic int request_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (burst_mode || pick < 55) begin
			return 0;
		end else if (pick < 85) begin
			return $urandom_range(1, 3);
		end else if (pick < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 40);
	endfunction

	// Present one request, hold it until the port takes it, then record it.
	// Valid stays up into the next request when no gap follows, so it never
	// drops and rises within the same step.
	task automatic send_request(input logic [1:0] kind, input logic [2:0] idx,
		input logic [WORD_W-1:0] wdata, input logic [WORD_W-1:0] levels);
		gpioirq_pkg::req_t r;
		int                gap;
		r.req_type   = kind;
		r.reg_index  = idx;
		r.write_data = wdata;
		r.pin_levels = levels;
		req_valid <= 1'b1;
		req       <= r;
		// Stall is sampled as it stood at the edge, so the exit edge is the accepting one
		do @(posedge clk); while (req_stall);
		port_model.apply_request(r);
		if (kind == gpioirq_pkg::REQ_TICK) begin
			sent_levels = levels;
		end
		gap = request_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Pick a word that favors the extremes now and then
	function automatic logic [WORD_W-1:0] pick_word();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			return '0;
		end else if (pick < 24) begin
			return '1;
		end
		return $urandom();
	endfunction

	// Next pin sample: often a few pins toggling so edges stay sparse and visible
	function automatic logic [WORD_W-1:0] pick_levels();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			return $urandom();
		end else if (pick < 80) begin
			return sent_levels ^ ($urandom() & $urandom() & $urandom());
		end else if (pick < 90) begin
			return sent_levels;
		end
		return pick_word();
	endfunction

	// Check every response taken by the receiver
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall && port_model != null) begin
			port_model.compare_response(rsp);
		end
	end

	// Receiver back-pressure: open stretches of varying length, then stall runs
	initial begin
		int open_len;
		int hold_len;
		int pick;
		@(posedge clk);
		forever begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				open_len = $urandom_range(1, 3);
			end else if (pick < 85) begin
				open_len = $urandom_range(4, 20);
			end else begin
				open_len = $urandom_range(50, 150);
			end
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				hold_len = 1;
			end else if (pick < 92) begin
				hold_len = $urandom_range(2, 5);
			end else begin
				hold_len = $urandom_range(10, 40);
			end
			rsp_stall <= 1'b0;
			repeat (open_len) @(posedge clk);
			rsp_stall <= 1'b1;
			repeat (hold_len) @(posedge clk);
		end
	end

	// Main sequence: reset, directed corners, random traffic, drain
	initial begin
		int                pick;
		logic [1:0]        kind;
		logic [2:0]        idx;
		logic [WORD_W-1:0] wdata;
		port_model = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values, then a low-level tick that latches every pin
		send_request(gpioirq_pkg::REQ_READ, gpioirq_pkg::REG_DATA, '0, '0);
		send_request(gpioirq_pkg::REQ_TICK, gpioirq_pkg::REG_DATA, '0, '0);
		send_request(gpioirq_pkg::REQ_READ, gpioirq_pkg::REG_STATUS, '0, '1);
		send_request(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_MASK, '1, '0);
		send_request(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_STATUS, '1, '0);
		// High level on the low half, rising edge on the high half
		send_request(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_ICR_LO, 32'h5555_5555, '0);
		send_request(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_ICR_HI, 32'hAAAA_AAAA, '0);
		send_request(gpioirq_pkg::REQ_TICK, REG_SPARE, '1, '1);
		send_request(gpioirq_pkg::REQ_READ, gpioirq_pkg::REG_STATUS, '0, '0);
		send_request(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_STATUS, 32'h0000_FFFF, '0);
		// Falling edge everywhere
		send_request(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_ICR_HI, '1, '0);
		send_request(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_ICR_LO, '1, '0);
		send_request(gpioirq_pkg::REQ_TICK, gpioirq_pkg::REG_DATA, '0, '0);
		send_request(gpioirq_pkg::REQ_READ, gpioirq_pkg::REG_ICR_LO, '0, '0);
		send_request(gpioirq_pkg::REQ_READ, gpioirq_pkg::REG_ICR_HI, '0, '0);
		// Both-edge override: a change sets status, a repeat sample does not
		send_request(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_BOTH, '1, '0);
		send_request(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_STATUS, '1, '0);
		send_request(gpioirq_pkg::REQ_TICK, gpioirq_pkg::REG_DATA, '0, 32'hA5A5_A5A5);
		send_request(gpioirq_pkg::REQ_TICK, gpioirq_pkg::REG_DATA, '0, 32'hA5A5_A5A5);
		send_request(gpioirq_pkg::REQ_READ, gpioirq_pkg::REG_BOTH, '0, '0);
		// Pad drive, the spare register slot and the spare request type
		send_request(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_DATA, '1, '0);
		send_request(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_DIR, '1, '0);
		send_request(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_DIR, 32'h0F0F_0F0F, '0);
		send_request(gpioirq_pkg::REQ_WRITE, REG_SPARE, '1, '0);
		send_request(gpioirq_pkg::REQ_READ, REG_SPARE, '1, '1);
		send_request(REQ_SPARE, REG_SPARE, '1, '1);
		send_request(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_MASK, '0, '0);

		// Random traffic: ticks dominate, writes keep reshaping modes and masks
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 64 == 0) begin
				burst_mode = ($urandom_range(0, 3) == 0);
			end
			pick  = $urandom_range(0, 99);
			idx   = 3'($urandom_range(0, 7));
			wdata = pick_word();
			if (pick < 40) begin
				kind = gpioirq_pkg::REQ_TICK;
			end else if (pick < 70) begin
				kind = gpioirq_pkg::REQ_WRITE;
				// Clear only a few status bits so the rest stay visible
				if (idx == gpioirq_pkg::REG_STATUS && $urandom_range(0, 1) == 1) begin
					wdata = $urandom() & $urandom() & $urandom();
				end
			end else if (pick < 95) begin
				kind = gpioirq_pkg::REQ_READ;
			end else begin
				kind = REQ_SPARE;
			end
			send_request(kind, idx, wdata, pick_levels());
		end

		// Drain every outstanding response, then let the pipeline settle
		req_valid <= 1'b0;
		while (port_model.outstanding() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (port_model.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog: stop a hung run
	initial begin
		#8_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
